/* rtl/assert_macros.svh */
// assertion macros for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define AFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, clocked on aclk, off during reset
`define AFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* rtl/afd_pkg.sv */
// package: constants, types, the exp table function and the grid cell count function of the detection decoder
package afd_pkg;

    localparam int MAX_CLASSES      = 16;
    localparam int MAX_FRAME_DIM    = 4096;
    localparam int EXP_TABLE_DEPTH  = 256;

    localparam int FRAME_W   = 13;
    localparam int GRID_W    = 10;
    localparam int CLASS_W   = 4;
    localparam int PROB_W    = 16;
    localparam int RAW_W     = 16;
    localparam int ANCHOR_W  = 16;
    localparam int POS_W     = 20;
    localparam int SIZE_W    = 19;
    localparam int EXP_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CLASS_W-1:0] CLASS_LIMIT = CLASS_W'(MAX_CLASSES - 1);
    localparam logic [FRAME_W:0]   FRAME_CLAMP = (FRAME_W + 1)'(MAX_FRAME_DIM);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_VALID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENTRIES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_KEEP_MASK = 3'd6;

    localparam longint LOG2E_Q30 = 64'sd1549082005;
    localparam longint LN2_Q30   = 64'sd744261118;
    localparam longint ONE_Q30   = 64'sd1073741824;

    typedef struct packed {
        logic [FRAME_W-1:0]    frame_width;
        logic [FRAME_W-1:0]    frame_height;
        logic [PROB_W-1:0]     score_threshold;
        logic [15:0]           remap_valid;
        logic [CFG_DATA_W-1:0] remap_entries;
        logic                  filter_on;
        logic [15:0]           class_keep_mask;
    } cfg_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_cx;
        logic signed [RAW_W-1:0] raw_cy;
        logic signed [RAW_W-1:0] raw_log_w;
        logic signed [RAW_W-1:0] raw_log_h;
        logic [PROB_W-1:0]       objectness;
        logic [PROB_W-1:0]       best_prob;
        logic [CLASS_W-1:0]      best_class;
        logic [GRID_W-1:0]       grid_col;
        logic [GRID_W-1:0]       grid_row;
        logic [1:0]              level;
        logic [ANCHOR_W-1:0]     anchor_number;
    } job_t;

    typedef struct packed {
        logic signed [POS_W-1:0] box_left;
        logic signed [POS_W-1:0] box_top;
        logic [SIZE_W-1:0]       box_width;
        logic [SIZE_W-1:0]       box_height;
        logic [PROB_W-1:0]       score;
        logic [CLASS_W-1:0]      class_id;
        logic [ANCHOR_W-1:0]     anchor_number;
    } result_t;

    // exp(x) in Q.20 for x in Q.28, as 2^(x*log2e) with a taylor series
    function automatic logic [EXP_W-1:0] exp_entry(input longint x);
        longint y;
        longint n;
        longint f;
        longint z;
        longint term;
        longint sum;
        longint r;
        y = (x * LOG2E_Q30) >>> 28;
        n = y >>> 30;
        f = y - n * ONE_Q30;
        z = (f * LN2_Q30) >>> 30;
        term = ONE_Q30;
        sum = ONE_Q30;
        // terms z^k / k! for k = 1 to 14, floored at every step
        term = (term * z) >>> 30;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd2;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd3;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd4;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd5;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd6;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd7;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd8;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd9;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd10;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd11;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd12;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd13;
        sum = sum + term;
        term = ((term * z) >>> 30) / 64'sd14;
        sum = sum + term;
        if (n >= 10) begin
            r = sum <<< (n - 10);
        end else begin
            r = (sum + (64'sd1 <<< (9 - n))) >>> (10 - n);
        end
        return r[EXP_W-1:0];
    endfunction

    // cells per grid row or column at a level, at least one
    function automatic logic [GRID_W:0] cell_count(input logic [FRAME_W-1:0] dim,
                                                   input logic [1:0] lvl);
        logic [FRAME_W:0] d;
        logic [FRAME_W:0] c;
        d = ({1'b0, dim} > FRAME_CLAMP) ? FRAME_CLAMP : {1'b0, dim};
        c = d >> (3 + lvl);
        if (c == '0) begin
            c = (FRAME_W + 1)'(1);
        end
        return c[GRID_W:0];
    endfunction

endpackage

/* rtl/afd_cfg_regs.sv */
// configuration register file with its write channel
module afd_cfg_regs import afd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width     <= FRAME_W'(640);
            cfg_reg.frame_height    <= FRAME_W'(640);
            cfg_reg.score_threshold <= 16'd32768;
            cfg_reg.remap_valid     <= '0;
            cfg_reg.remap_entries   <= '0;
            cfg_reg.filter_on       <= 1'b0;
            cfg_reg.class_keep_mask <= 16'hFFFF;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_data[FRAME_W-1:0];
                CFG_SCORE_THRESHOLD: cfg_reg.score_threshold <= cfg_data[PROB_W-1:0];
                CFG_REMAP_VALID:     cfg_reg.remap_valid     <= cfg_data[15:0];
                CFG_REMAP_ENTRIES:   cfg_reg.remap_entries   <= cfg_data;
                CFG_FILTER_ON:       cfg_reg.filter_on       <= cfg_data[0];
                CFG_CLASS_KEEP_MASK: cfg_reg.class_keep_mask <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/afd_anchor_track.sv */
// input stage: best class tracking, grid counters and the decode job register
module afd_anchor_track import afd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_frame_start,
    input  logic signed [RAW_W-1:0]  s_raw_cx,
    input  logic signed [RAW_W-1:0]  s_raw_cy,
    input  logic signed [RAW_W-1:0]  s_raw_log_w,
    input  logic signed [RAW_W-1:0]  s_raw_log_h,
    input  logic [PROB_W-1:0]        s_objectness,
    input  logic [PROB_W-1:0]        s_class_prob,
    input  logic                     s_class_last,
    input  cfg_t                     cfg,
    input  logic                     job_take,
    output logic                     job_valid,
    output job_t                     job
);

    logic [PROB_W-1:0]   best_prob_reg;
    logic [CLASS_W-1:0]  best_class_reg;
    logic [CLASS_W-1:0]  class_count_reg;
    logic                class_over_reg;
    logic [GRID_W-1:0]   grid_col_reg;
    logic [GRID_W-1:0]   grid_row_reg;
    logic [1:0]          grid_level_reg;
    logic [ANCHOR_W-1:0] anchor_count_reg;
    logic                job_valid_reg;
    job_t                job_reg;

    logic                accept;
    logic [PROB_W-1:0]   cur_prob;
    logic [CLASS_W-1:0]  cur_class;
    logic [CLASS_W-1:0]  cur_count;
    logic                cur_over;
    logic [GRID_W-1:0]   cur_col;
    logic [GRID_W-1:0]   cur_row;
    logic [1:0]          cur_level;
    logic [ANCHOR_W-1:0] cur_anchor;
    logic                take_new;
    logic [PROB_W-1:0]   best_prob_next;
    logic [CLASS_W-1:0]  best_class_next;
    logic [CLASS_W-1:0]  class_count_next;
    logic                class_over_next;
    logic [1:0]          lvl;
    logic [GRID_W:0]     cells_w;
    logic [GRID_W:0]     cells_h;
    logic [GRID_W:0]     col_inc;
    logic [GRID_W:0]     row_inc;
    logic [GRID_W-1:0]   grid_col_next;
    logic [GRID_W-1:0]   grid_row_next;
    logic [1:0]          grid_level_next;
    job_t                job_next;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !job_valid_reg || job_take;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        // a frame start clears everything before this word counts
        cur_prob   = s_frame_start ? '0 : best_prob_reg;
        cur_class  = s_frame_start ? '0 : best_class_reg;
        cur_count  = s_frame_start ? '0 : class_count_reg;
        cur_over   = s_frame_start ? 1'b0 : class_over_reg;
        cur_col    = s_frame_start ? '0 : grid_col_reg;
        cur_row    = s_frame_start ? '0 : grid_row_reg;
        cur_level  = s_frame_start ? '0 : grid_level_reg;
        cur_anchor = s_frame_start ? '0 : anchor_count_reg;

        take_new = !cur_over && (cur_count == '0 || s_class_prob > cur_prob);
        best_prob_next  = take_new ? s_class_prob : cur_prob;
        best_class_next = take_new ? cur_count : cur_class;
        class_over_next = cur_over || (cur_count >= CLASS_LIMIT);
        class_count_next = (cur_count >= CLASS_LIMIT) ? cur_count : cur_count + 1'b1;

        lvl     = (cur_level > 2'd2) ? 2'd0 : cur_level;
        cells_w = cell_count(cfg.frame_width, lvl);
        cells_h = cell_count(cfg.frame_height, lvl);
        col_inc = {1'b0, cur_col} + 1'b1;
        row_inc = {1'b0, cur_row} + 1'b1;
        grid_col_next   = col_inc[GRID_W-1:0];
        grid_row_next   = cur_row;
        grid_level_next = lvl;
        if (col_inc >= cells_w) begin
            grid_col_next = '0;
            grid_row_next = row_inc[GRID_W-1:0];
            if (row_inc >= cells_h) begin
                grid_row_next   = '0;
                grid_level_next = (lvl >= 2'd2) ? 2'd0 : lvl + 1'b1;
            end
        end

        job_next.raw_cx        = s_raw_cx;
        job_next.raw_cy        = s_raw_cy;
        job_next.raw_log_w     = s_raw_log_w;
        job_next.raw_log_h     = s_raw_log_h;
        job_next.objectness    = s_objectness;
        job_next.best_prob     = best_prob_next;
        job_next.best_class    = best_class_next;
        job_next.grid_col      = cur_col;
        job_next.grid_row      = cur_row;
        job_next.level         = lvl;
        job_next.anchor_number = cur_anchor;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_prob_reg    <= '0;
            best_class_reg   <= '0;
            class_count_reg  <= '0;
            class_over_reg   <= 1'b0;
            grid_col_reg     <= '0;
            grid_row_reg     <= '0;
            grid_level_reg   <= '0;
            anchor_count_reg <= '0;
            job_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                if (s_class_last) begin
                    best_prob_reg    <= '0;
                    best_class_reg   <= '0;
                    class_count_reg  <= '0;
                    class_over_reg   <= 1'b0;
                    grid_col_reg     <= grid_col_next;
                    grid_row_reg     <= grid_row_next;
                    grid_level_reg   <= grid_level_next;
                    anchor_count_reg <= cur_anchor + 1'b1;
                end else begin
                    best_prob_reg    <= best_prob_next;
                    best_class_reg   <= best_class_next;
                    class_count_reg  <= class_count_next;
                    class_over_reg   <= class_over_next;
                    grid_col_reg     <= cur_col;
                    grid_row_reg     <= cur_row;
                    grid_level_reg   <= cur_level;
                    anchor_count_reg <= cur_anchor;
                end
            end
            if (accept && s_class_last) begin
                job_valid_reg <= 1'b1;
            end else if (job_take) begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_class_last) begin
            job_reg <= job_next;
        end
    end

endmodule

/* rtl/afd_box_decode.sv */
// decode stage: score, class remap and filter, box centre and exp sizes
module afd_box_decode import afd_pkg::*; #(
    parameter int EXP_TABLE_SIZE = EXP_TABLE_DEPTH
) (
    input  job_t    job,
    input  cfg_t    cfg,
    output logic    emit,
    output result_t result
);

    localparam int IDX_W  = $clog2(EXP_TABLE_SIZE);
    localparam int PROD_W = RAW_W + $clog2(EXP_TABLE_SIZE + 1);
    localparam int SZ_W   = EXP_W + 5;
    localparam int ACC_W  = 41;

    logic [EXP_W-1:0] exp_rom [EXP_TABLE_SIZE];

    for (genvar g = 0; g < EXP_TABLE_SIZE; g++) begin : g_exp
        localparam longint XQ28 =
            (((64'sd2 * g + 64'sd1) <<< 31) / EXP_TABLE_SIZE) - (64'sd8 <<< 28);
        localparam logic [EXP_W-1:0] ENTRY = exp_entry(XQ28);
        assign exp_rom[g] = ENTRY;
    end

    logic [2*PROB_W-1:0]     score_prod;
    logic [PROB_W-1:0]       score;
    logic [CLASS_W-1:0]      cls;
    logic [2:0]              sh;
    logic [PROD_W-1:0]       idx_w_prod;
    logic [PROD_W-1:0]       idx_h_prod;
    logic [IDX_W-1:0]        idx_w;
    logic [IDX_W-1:0]        idx_h;
    logic [SZ_W-1:0]         w20;
    logic [SZ_W-1:0]         h20;
    logic signed [23:0]      cx_sum;
    logic signed [23:0]      cy_sum;
    logic signed [ACC_W-1:0] left_acc;
    logic signed [ACC_W-1:0] top_acc;
    logic signed [ACC_W-1:0] left_q4;
    logic signed [ACC_W-1:0] top_q4;
    logic [SZ_W:0]           w_round;
    logic [SZ_W:0]           h_round;
    logic [SZ_W-16:0]        w4;
    logic [SZ_W-16:0]        h4;

    always_comb begin
        score_prod = job.objectness * job.best_prob;
        score      = score_prod[2*PROB_W-1:PROB_W];

        cls = job.best_class;
        if (cfg.remap_valid[cls]) begin
            cls = cfg.remap_entries[4*cls +: CLASS_W];
        end
        emit = (score > cfg.score_threshold)
            && (!cfg.filter_on || cfg.class_keep_mask[cls]);

        sh = 3'd3 + {1'b0, job.level};

        // index = ((raw + 32768) * size) >> 16, always below the table size
        idx_w_prod = PROD_W'({~job.raw_log_w[RAW_W-1], job.raw_log_w[RAW_W-2:0]})
            * PROD_W'(EXP_TABLE_SIZE);
        idx_h_prod = PROD_W'({~job.raw_log_h[RAW_W-1], job.raw_log_h[RAW_W-2:0]})
            * PROD_W'(EXP_TABLE_SIZE);
        idx_w = idx_w_prod[RAW_W +: IDX_W];
        idx_h = idx_h_prod[RAW_W +: IDX_W];
        w20 = SZ_W'(exp_rom[idx_w]) << sh;
        h20 = SZ_W'(exp_rom[idx_h]) << sh;

        cx_sum = $signed({2'b00, job.grid_col, 12'd0}) + 24'(job.raw_cx);
        cy_sum = $signed({2'b00, job.grid_row, 12'd0}) + 24'(job.raw_cy);

        // corner in Q.21, rounded half up to Q.4
        left_acc = (ACC_W'(cx_sum) <<< (sh + 4'd9)) - $signed(ACC_W'(w20))
            + ACC_W'(65536);
        top_acc  = (ACC_W'(cy_sum) <<< (sh + 4'd9)) - $signed(ACC_W'(h20))
            + ACC_W'(65536);
        left_q4 = left_acc >>> 17;
        top_q4  = top_acc >>> 17;

        w_round = {1'b0, w20} + (SZ_W + 1)'(32768);
        h_round = {1'b0, h20} + (SZ_W + 1)'(32768);
        w4 = w_round[SZ_W:16];
        h4 = h_round[SZ_W:16];

        if (left_q4 > ACC_W'(524287)) begin
            result.box_left = 20'sh7FFFF;
        end else if (left_q4 < -ACC_W'(524288)) begin
            result.box_left = 20'sh80000;
        end else begin
            result.box_left = left_q4[POS_W-1:0];
        end
        if (top_q4 > ACC_W'(524287)) begin
            result.box_top = 20'sh7FFFF;
        end else if (top_q4 < -ACC_W'(524288)) begin
            result.box_top = 20'sh80000;
        end else begin
            result.box_top = top_q4[POS_W-1:0];
        end
        result.box_width  = (w4 > (SZ_W - 15)'(524287)) ? 19'h7FFFF : w4[SIZE_W-1:0];
        result.box_height = (h4 > (SZ_W - 15)'(524287)) ? 19'h7FFFF : h4[SIZE_W-1:0];
        result.score         = score;
        result.class_id      = cls;
        result.anchor_number = job.anchor_number;
    end

endmodule

/* rtl/anchor_free_detection_decoder.sv */
// top level: anchor-free detection decoder with result register and checks
// Takes one class-probability word per cycle while s_ready is high. Each
// anchor's last class word is latched into a job register; from there the
// box is decoded in one pass (score multiply, exp table lookups, corner math)
// and loaded into the result register once the result register is free.
// Words with no result, and anchors that fail the score or class filter,
// leave no output. The exp table is a constant of EXP_TABLE_SIZE entries
// built at elaboration. Input backpressure reaches s_ready only when the
// result register is full and not being read. Configuration writes are
// accepted every cycle and must be made while idle.
`include "assert_macros.svh"

module anchor_free_detection_decoder import afd_pkg::*; #(
    parameter int EXP_TABLE_SIZE = EXP_TABLE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_frame_start,
    input  logic signed [RAW_W-1:0]  s_raw_cx,
    input  logic signed [RAW_W-1:0]  s_raw_cy,
    input  logic signed [RAW_W-1:0]  s_raw_log_w,
    input  logic signed [RAW_W-1:0]  s_raw_log_h,
    input  logic [PROB_W-1:0]        s_objectness,
    input  logic [PROB_W-1:0]        s_class_prob,
    input  logic                     s_class_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [POS_W-1:0]  m_box_left,
    output logic signed [POS_W-1:0]  m_box_top,
    output logic [SIZE_W-1:0]        m_box_width,
    output logic [SIZE_W-1:0]        m_box_height,
    output logic [PROB_W-1:0]        m_score,
    output logic [CLASS_W-1:0]       m_class_id,
    output logic [ANCHOR_W-1:0]      m_anchor_number
);

    cfg_t    cfg;
    job_t    job;
    logic    job_valid;
    logic    job_take;
    logic    emit;
    logic    out_free;
    logic    load;
    result_t result;
    result_t res_reg;
    logic    m_valid_reg;

    afd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afd_anchor_track u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_start (s_frame_start),
        .s_raw_cx      (s_raw_cx),
        .s_raw_cy      (s_raw_cy),
        .s_raw_log_w   (s_raw_log_w),
        .s_raw_log_h   (s_raw_log_h),
        .s_objectness  (s_objectness),
        .s_class_prob  (s_class_prob),
        .s_class_last  (s_class_last),
        .cfg           (cfg),
        .job_take      (job_take),
        .job_valid     (job_valid),
        .job           (job)
    );

    afd_box_decode #(
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_decode (
        .job    (job),
        .cfg    (cfg),
        .emit   (emit),
        .result (result)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign job_take = job_valid && (out_free || !emit);
    assign load     = job_valid && emit && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_box_left      = res_reg.box_left;
    assign m_box_top       = res_reg.box_top;
    assign m_box_width     = res_reg.box_width;
    assign m_box_height    = res_reg.box_height;
    assign m_score         = res_reg.score;
    assign m_class_id      = res_reg.class_id;
    assign m_anchor_number = res_reg.anchor_number;

    `AFD_ASSERT_NOW(a_ready_when_empty, !job_valid, s_ready)
    `AFD_ASSERT_NEXT(a_word_from_job, !m_valid_reg, !m_valid_reg || $past(job_valid))
    `AFD_ASSERT_NOW(a_score_above, m_valid_reg, m_score > cfg.score_threshold)
    `AFD_ASSERT_NOW(a_class_kept, m_valid_reg && cfg.filter_on, cfg.class_keep_mask[m_class_id])

endmodule
